FILE: hw/rtl/free_space_max_tree_top_assert.svh
// Assertion macros for the free-space max tree block.
// Used by free_space_max_tree_top; expects clk and rst_n in scope.
`ifndef FREE_SPACE_MAX_TREE_TOP_ASSERT_SVH
`define FREE_SPACE_MAX_TREE_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FSMT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fsmt assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define FSMT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fsmt assertion failed");

`endif

FILE: hw/rtl/fsmt_pkg.sv
// Shared types and constants of the free-space max tree block.
// No dependencies; used by the interfaces and imported by all modules.
package fsmt_pkg;

    localparam int ACT_W  = 2;
    localparam int PAGE_W = 14;
    localparam int CAT_W  = 8;

    // Reciprocal scaling for page / LEAF_COUNT; must be at least PAGE_W.
    localparam int RECIP_SHIFT = 16;

    localparam logic [ACT_W-1:0] ACT_UPDATE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [PAGE_W-1:0] page_number;
        logic [CAT_W-1:0]  category_value;
    } req_t;

    typedef struct packed {
        logic              found;
        logic [PAGE_W-1:0] result_page;
        logic [CAT_W-1:0]  result_category;
        logic              out_of_range;
    } rsp_t;

    typedef struct packed {
        logic             ge;
        logic             eq;
        logic [CAT_W-1:0] max_val;
    } cmp_t;

endpackage

FILE: hw/rtl/fsmt_if.sv
// Valid/ready channel interfaces for request and response transactions.
// Depends on fsmt_pkg for the payload types.
interface fsmt_req_if;
    logic          valid;
    logic          ready;
    fsmt_pkg::req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface fsmt_rsp_if;
    logic          valid;
    logic          ready;
    fsmt_pkg::rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/fsmt_node_cmp.sv
// Shared category compare unit: greater-or-equal, equality and maximum.
// Depends on fsmt_pkg.
module fsmt_node_cmp (
    input  logic [fsmt_pkg::CAT_W-1:0] a,
    input  logic [fsmt_pkg::CAT_W-1:0] b,
    output fsmt_pkg::cmp_t             res
);
    import fsmt_pkg::*;

    assign res.ge      = (a >= b);
    assign res.eq      = (a == b);
    assign res.max_val = (a >= b) ? a : b;

endmodule

FILE: hw/rtl/fsmt_node_ram.sv
// Tree node store: one write port, one read port with registered read data.
// Depends on fsmt_pkg.
module fsmt_node_ram #(
    parameter int  DEPTH = 32764,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [AW-1:0]              wr_addr,
    input  logic [fsmt_pkg::CAT_W-1:0] wr_data,
    input  logic [AW-1:0]              rd_addr,
    output logic [fsmt_pkg::CAT_W-1:0] rd_data
);
    import fsmt_pkg::*;

    logic [CAT_W-1:0] mem [DEPTH];
    logic [CAT_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/fsmt_page_split.sv
// Splits a data page number into map page index and leaf slot.
// Reciprocal multiply, back multiply, one correction step. Depends on fsmt_pkg.
module fsmt_page_split #(
    parameter int  LEAF_COUNT = 4096,
    localparam int SW         = $clog2(LEAF_COUNT)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [fsmt_pkg::PAGE_W-1:0] page_number,
    output logic                        done,
    output logic [fsmt_pkg::PAGE_W-1:0] map_idx,
    output logic [SW-1:0]               slot
);
    import fsmt_pkg::*;

    localparam int LCW   = $clog2(LEAF_COUNT + 1);
    localparam int RECIP = (1 << RECIP_SHIFT) / LEAF_COUNT;
    localparam int P1W   = PAGE_W + RECIP_SHIFT;
    localparam int P2W   = PAGE_W + LCW;
    localparam int EW    = ((LCW > PAGE_W) ? LCW : PAGE_W) + 1;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_QUOT = 2'd1;
    localparam logic [1:0] PH_BACK = 2'd2;
    localparam logic [1:0] PH_FIX  = 2'd3;

    logic [1:0]        ph_reg, ph_next;
    logic              done_reg, done_next;
    logic [PAGE_W-1:0] pn_reg, pn_next;
    logic [PAGE_W-1:0] q_reg, q_next;
    logic [PAGE_W-1:0] back_reg, back_next;
    logic [PAGE_W-1:0] map_reg, map_next;
    logic [SW-1:0]     slot_reg, slot_next;

    logic [P1W-1:0]    prod1;
    logic [P2W-1:0]    prod2;
    logic [PAGE_W-1:0] rem;
    logic [EW-1:0]     rem_ext;
    logic [EW-1:0]     rem_fix;
    logic              over;

    // estimate is exact or one low, so the remainder is below twice LEAF_COUNT
    assign prod1   = P1W'(pn_reg) * P1W'(RECIP);
    assign prod2   = P2W'(q_reg) * P2W'(LEAF_COUNT);
    assign rem     = pn_reg - back_reg;
    assign rem_ext = EW'(rem);
    assign over    = (rem_ext >= EW'(LEAF_COUNT));
    assign rem_fix = over ? (rem_ext - EW'(LEAF_COUNT)) : rem_ext;

    always_comb
    begin
        ph_next   = ph_reg;
        done_next = 1'b0;
        pn_next   = pn_reg;
        q_next    = q_reg;
        back_next = back_reg;
        map_next  = map_reg;
        slot_next = slot_reg;
        unique case (ph_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    pn_next = page_number;
                    ph_next = PH_QUOT;
                end
            end
            PH_QUOT:
            begin
                q_next  = prod1[RECIP_SHIFT +: PAGE_W];
                ph_next = PH_BACK;
            end
            PH_BACK:
            begin
                back_next = prod2[PAGE_W-1:0];
                ph_next   = PH_FIX;
            end
            PH_FIX:
            begin
                map_next  = over ? (q_reg + PAGE_W'(1)) : q_reg;
                slot_next = SW'(rem_fix);
                done_next = 1'b1;
                ph_next   = PH_IDLE;
            end
            default:
            begin
                ph_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= PH_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            ph_reg   <= ph_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pn_reg   <= pn_next;
        q_reg    <= q_next;
        back_reg <= back_next;
        map_reg  <= map_next;
        slot_reg <= slot_next;
    end

    assign done    = done_reg;
    assign map_idx = map_reg;
    assign slot    = slot_reg;

endmodule

FILE: hw/rtl/free_space_max_tree_top.sv
// free_space_max_tree_top: free-space map of MAP_PAGES max trees, one transaction at a time.
// Update writes the leaf and bubbles the maximum up at most log2(LEAF_COUNT) levels; an
// out-of-range update or a read of a map page not in use goes straight to the response.
// Search checks roots in turn, then descends, trying the right child when the left is short.
// Reset: a clearing pass zeroes all MAP_PAGES*(2*LEAF_COUNT-1) nodes, one a cycle (32764 at the
// defaults), with req.ready low; depends on fsmt_pkg, fsmt_if, node_cmp, node_ram, page_split.
`include "free_space_max_tree_top_assert.svh"

module free_space_max_tree_top #(
    parameter int LEAF_COUNT = 4096,
    parameter int MAP_PAGES  = 4
) (
    input logic        clk,
    input logic        rst_n,
    fsmt_req_if.sink   req,
    fsmt_rsp_if.source rsp
);
    import fsmt_pkg::*;

    // implicit heap per map page: inner nodes first, then leaves
    localparam int NODES = 2 * LEAF_COUNT - 1;
    localparam int INNER = LEAF_COUNT - 1;
    localparam int DEPTH = MAP_PAGES * NODES;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(NODES);
    localparam int SW    = $clog2(LEAF_COUNT);
    localparam int CW    = $clog2(MAP_PAGES + 1);

    localparam logic [3:0] S_CLEAR      = 4'd0;
    localparam logic [3:0] S_IDLE       = 4'd1;
    localparam logic [3:0] S_SPLIT      = 4'd2;
    localparam logic [3:0] S_U_LEAF_RD  = 4'd3;
    localparam logic [3:0] S_U_LEAF_CHK = 4'd4;
    localparam logic [3:0] S_U_SIB_RD   = 4'd5;
    localparam logic [3:0] S_U_PAR_RD   = 4'd6;
    localparam logic [3:0] S_U_PAR_CHK  = 4'd7;
    localparam logic [3:0] S_R_RD       = 4'd8;
    localparam logic [3:0] S_R_CHK      = 4'd9;
    localparam logic [3:0] S_S_ROOT_RD  = 4'd10;
    localparam logic [3:0] S_S_ROOT_CHK = 4'd11;
    localparam logic [3:0] S_S_KID_RD   = 4'd12;
    localparam logic [3:0] S_S_KID_CHK  = 4'd13;
    localparam logic [3:0] S_RESP       = 4'd14;

    // control state
    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [CW-1:0] used_reg, used_next;
    logic          rsp_valid_reg, rsp_valid_next;

    // transaction payload and walk registers
    logic [ACT_W-1:0]  act_reg, act_next;
    logic [CAT_W-1:0]  cat_reg, cat_next;
    logic [AW-1:0]     base_reg, base_next;
    logic [NW-1:0]     node_reg, node_next;
    logic [CAT_W-1:0]  cur_reg, cur_next;
    logic [CAT_W-1:0]  mx_reg, mx_next;
    logic              side_reg, side_next;
    logic [CW-1:0]     msel_reg, msel_next;
    logic [PAGE_W-1:0] pbase_reg, pbase_next;
    logic              found_p_reg, found_p_next;
    logic [PAGE_W-1:0] page_p_reg, page_p_next;
    logic [CAT_W-1:0]  cat_p_reg, cat_p_next;
    logic              oor_p_reg, oor_p_next;
    rsp_t              rsp_data_reg, rsp_data_next;

    // memory and shared unit hookup
    logic             mem_we;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;
    logic [CAT_W-1:0] wr_data;
    logic [CAT_W-1:0] rd_data;
    logic [NW-1:0]    rd_node;
    logic [NW-1:0]    wr_node;
    logic [NW-1:0]    sib_node;
    logic [NW-1:0]    par_node;
    logic [NW-1:0]    kid_node;
    logic [CAT_W-1:0] cmp_a;
    logic [CAT_W-1:0] cmp_b;
    cmp_t             cmp_res;
    logic             last_map;

    logic              split_start;
    logic              split_done;
    logic [PAGE_W-1:0] split_map;
    logic [SW-1:0]     split_slot;

    fsmt_node_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // split captures the page number in the accepting cycle
    fsmt_page_split #(
        .LEAF_COUNT (LEAF_COUNT)
    ) u_split (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (split_start),
        .page_number (req.payload.page_number),
        .done        (split_done),
        .map_idx     (split_map),
        .slot        (split_slot)
    );

    fsmt_node_cmp u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp_res)
    );

    // heap neighbors of the current node
    assign sib_node = node_reg[0] ? (node_reg + NW'(1)) : (node_reg - NW'(1));
    assign par_node = (node_reg - NW'(1)) >> 1;
    assign kid_node = (node_reg << 1) + NW'(1) + NW'(side_reg);
    assign last_map = ((msel_reg + CW'(1)) == used_reg);

    assign wr_addr = (state_reg == S_CLEAR) ? clr_reg : (base_reg + AW'(wr_node));
    assign rd_addr = base_reg + AW'(rd_node);

    assign req.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        used_next      = used_reg;
        rsp_valid_next = rsp_valid_reg;
        act_next       = act_reg;
        cat_next       = cat_reg;
        base_next      = base_reg;
        node_next      = node_reg;
        cur_next       = cur_reg;
        mx_next        = mx_reg;
        side_next      = side_reg;
        msel_next      = msel_reg;
        pbase_next     = pbase_reg;
        found_p_next   = found_p_reg;
        page_p_next    = page_p_reg;
        cat_p_next     = cat_p_reg;
        oor_p_next     = oor_p_reg;
        rsp_data_next  = rsp_data_reg;

        mem_we      = 1'b0;
        wr_node     = node_reg;
        wr_data     = cat_reg;
        rd_node     = node_reg;
        cmp_a       = rd_data;
        cmp_b       = cat_reg;
        split_start = 1'b0;

        // output register drains independently of the walk
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                wr_data  = '0;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    act_next     = req.payload.action;
                    cat_next     = req.payload.category_value;
                    found_p_next = 1'b0;
                    page_p_next  = '0;
                    cat_p_next   = '0;
                    oor_p_next   = 1'b0;
                    unique case (req.payload.action) inside
                        ACT_UPDATE, ACT_READ:
                        begin
                            // update and read echo the page and report found
                            found_p_next = 1'b1;
                            page_p_next  = req.payload.page_number;
                            split_start  = 1'b1;
                            state_next   = S_SPLIT;
                        end
                        ACT_SEARCH:
                        begin
                            msel_next  = '0;
                            base_next  = '0;
                            pbase_next = '0;
                            state_next = (used_reg == '0) ? S_RESP : S_S_ROOT_RD;
                        end
                        default:
                        begin
                            // unused action: all-zero result, tree left unchanged
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_SPLIT:
            begin
                if (split_done)
                begin
                    base_next = AW'(split_map[CW-1:0]) * AW'(NODES);
                    node_next = NW'(INNER) + NW'(split_slot);
                    if (act_reg == ACT_UPDATE)
                    begin
                        if (split_map >= PAGE_W'(MAP_PAGES))
                        begin
                            oor_p_next = 1'b1;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            if (PAGE_W'(used_reg) <= split_map)
                            begin
                                used_next = CW'(split_map + PAGE_W'(1));
                            end
                            state_next = S_U_LEAF_RD;
                        end
                    end
                    else
                    begin
                        // map page not in use reads as category zero
                        state_next = (PAGE_W'(used_reg) <= split_map) ? S_RESP : S_R_RD;
                    end
                end
            end
            S_U_LEAF_RD:
            begin
                state_next = S_U_LEAF_CHK;
            end
            S_U_LEAF_CHK:
            begin
                if (cmp_res.eq)
                begin
                    // unchanged leaf leaves the tree as it is
                    state_next = S_RESP;
                end
                else
                begin
                    mem_we     = 1'b1;
                    cur_next   = cat_reg;
                    state_next = S_U_SIB_RD;
                end
            end
            S_U_SIB_RD:
            begin
                rd_node    = sib_node;
                state_next = S_U_PAR_RD;
            end
            S_U_PAR_RD:
            begin
                // larger of the current node and its sibling
                rd_node    = par_node;
                cmp_a      = cur_reg;
                cmp_b      = rd_data;
                mx_next    = cmp_res.max_val;
                state_next = S_U_PAR_CHK;
            end
            S_U_PAR_CHK:
            begin
                cmp_b = mx_reg;
                if (cmp_res.eq)
                begin
                    // parent already holds the maximum: stop bubbling
                    state_next = S_RESP;
                end
                else
                begin
                    mem_we     = 1'b1;
                    wr_node    = par_node;
                    wr_data    = mx_reg;
                    node_next  = par_node;
                    cur_next   = mx_reg;
                    state_next = (par_node == '0) ? S_RESP : S_U_SIB_RD;
                end
            end
            S_R_RD:
            begin
                state_next = S_R_CHK;
            end
            S_R_CHK:
            begin
                cat_p_next = rd_data;
                state_next = S_RESP;
            end
            S_S_ROOT_RD:
            begin
                rd_node    = '0;
                state_next = S_S_ROOT_CHK;
            end
            S_S_ROOT_CHK:
            begin
                if (cmp_res.ge)
                begin
                    node_next  = '0;
                    side_next  = 1'b0;
                    state_next = S_S_KID_RD;
                end
                else if (last_map)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    msel_next  = msel_reg + CW'(1);
                    base_next  = base_reg + AW'(NODES);
                    pbase_next = pbase_reg + PAGE_W'(LEAF_COUNT);
                    state_next = S_S_ROOT_RD;
                end
            end
            S_S_KID_RD:
            begin
                rd_node    = kid_node;
                state_next = S_S_KID_CHK;
            end
            S_S_KID_CHK:
            begin
                if (cmp_res.ge)
                begin
                    node_next = kid_node;
                    side_next = 1'b0;
                    if (kid_node >= NW'(INNER))
                    begin
                        found_p_next = 1'b1;
                        page_p_next  = pbase_reg + PAGE_W'(kid_node - NW'(INNER));
                        state_next   = S_RESP;
                    end
                    else
                    begin
                        state_next = S_S_KID_RD;
                    end
                end
                else if (!side_reg)
                begin
                    // left child fails: try the right one
                    side_next  = 1'b1;
                    state_next = S_S_KID_RD;
                end
                else if (last_map)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    msel_next  = msel_reg + CW'(1);
                    base_next  = base_reg + AW'(NODES);
                    pbase_next = pbase_reg + PAGE_W'(LEAF_COUNT);
                    state_next = S_S_ROOT_RD;
                end
            end
            S_RESP:
            begin
                // wait here only while the previous transaction still sits unread
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_data_next.found           = found_p_reg;
                    rsp_data_next.result_page     = page_p_reg;
                    rsp_data_next.result_category = cat_p_reg;
                    rsp_data_next.out_of_range    = oor_p_reg;
                    rsp_valid_next                = 1'b1;
                    state_next                    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            used_reg      <= used_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        cat_reg      <= cat_next;
        base_reg     <= base_next;
        node_reg     <= node_next;
        cur_reg      <= cur_next;
        mx_reg       <= mx_next;
        side_reg     <= side_next;
        msel_reg     <= msel_next;
        pbase_reg    <= pbase_next;
        found_p_reg  <= found_p_next;
        page_p_reg   <= page_p_next;
        cat_p_reg    <= cat_p_next;
        oor_p_reg    <= oor_p_next;
        rsp_data_reg <= rsp_data_next;
    end

    // split result arrives only while the sequencer waits for it
    `FSMT_ASSERT_NOW(a_split_done_in_wait, split_done, state_reg == S_SPLIT)
    // node memory is written only by the clearing pass and the update walk
    `FSMT_ASSERT_NOW(a_write_states, mem_we, (state_reg == S_CLEAR) || (state_reg == S_U_LEAF_CHK) || (state_reg == S_U_PAR_CHK))
    // bubbling never asks for the parent of the root
    `FSMT_ASSERT_NOW(a_no_root_parent, (state_reg == S_U_SIB_RD) || (state_reg == S_U_PAR_CHK), node_reg != '0)
    // an accepted transaction always starts work
    `FSMT_ASSERT_NEXT(a_accept_leaves_idle, req.valid && req.ready, state_reg != S_IDLE)
    `FSMT_ASSERT_NOW(a_used_bound, 1'b1, used_reg <= CW'(MAP_PAGES))

endmodule
